@@ sv/assert_macros.svh @@
// Assertion macros for the RTL of the change trace encoder.
// Depends on nothing; files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is held off while reset is asserted.
`define PCTE_ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion that is checked at every rising clock edge.
`define PCTE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/pcte_pkg.sv @@
// Types and constants of the per-cycle change trace encoder.
// Used by the channel interfaces, the entry memory and the top level.
`default_nettype none

package pcte_pkg;

  localparam int MODE_W     = 3;
  localparam int KEY_W      = 16;
  localparam int VAL_W      = 16;
  localparam int SLOT_IDX_W = 4;
  localparam int HDR_REG_W  = 3;
  localparam int HDR_MEM_W  = 4;

  localparam logic [7:0] HDR_PSW_FLAG = 8'h80;

  typedef enum logic [MODE_W-1:0] {
    MODE_RESTART = 3'd0,
    MODE_FLAGS   = 3'd1,
    MODE_STATUS  = 3'd2,
    MODE_REG_WR  = 3'd3,
    MODE_MEM_WR  = 3'd4,
    MODE_END     = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PSW    = 2'd1,
    KIND_REG    = 2'd2,
    KIND_MEM    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HEAD,
    ST_PSW,
    ST_REG,
    ST_MEM
  } state_t;

  typedef struct packed {
    logic                  we;
    logic [SLOT_IDX_W-1:0] waddr;
    logic [KEY_W-1:0]      wkey;
    logic [VAL_W-1:0]      wval;
    logic                  re;
    logic [SLOT_IDX_W-1:0] raddr;
  } kv_req_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
  } kv_entry_t;

endpackage

`default_nettype wire

@@ sv/pcte_if.sv @@
// Valid/ready channel interfaces for trace events and change records.
// Depends on pcte_pkg for the field widths.
`default_nettype none

interface pcte_in_if
  import pcte_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [7:0]        flags_in;
  logic [7:0]        status_in;
  logic [3:0]        reg_index;
  logic [15:0]       reg_value;
  logic [15:0]       mem_address;
  logic [7:0]        mem_value;

  modport source (output valid, mode, flags_in, status_in, reg_index, reg_value,
                  mem_address, mem_value, input ready);
  modport sink (input valid, mode, flags_in, status_in, reg_index, reg_value,
                mem_address, mem_value, output ready);
endinterface

interface pcte_out_if
  import pcte_pkg::*;
();
  logic        valid;
  logic        ready;
  logic [1:0]  record_kind;
  logic [15:0] record_key;
  logic [15:0] record_value;
  logic        last;

  modport source (output valid, record_kind, record_key, record_value, last,
                  input ready);
  modport sink (input valid, record_kind, record_key, record_value, last,
                output ready);
endinterface

`default_nettype wire

@@ sv/pcte_kv_ram.sv @@
// Synchronous key/value entry memory, one write and one read port.
// Read data is registered and appears in the cycle after the read request. Uses pcte_pkg.
`default_nettype none

module pcte_kv_ram
  import pcte_pkg::*;
#(
  parameter int DEPTH = 7
) (
  input  wire logic      clk,
  input  wire kv_req_t   req,
  output kv_entry_t      rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  kv_entry_t mem [DEPTH];
  kv_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= '{key: req.wkey, val: req.wval};
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data_r <= mem[req.raddr[AW-1:0]];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ sv/per_cycle_change_trace_encoder.sv @@
// Flag, status and restart events update state from idle; a register or memory
// write goes straight into an empty table, else the stored entries are scanned.
// With tracing on, end of cycle emits one record per cycle when the output is free,
// the first record via the header state and output register; each stored
// entry is read from its memory. Reset is synchronous, active low: tracking empty,
// flags and status zero, tracing enabled. The entry memories are not cleared.
`default_nettype none
`include "assert_macros.svh"

module per_cycle_change_trace_encoder
  import pcte_pkg::*;
#(
  parameter int REG_SLOTS = 7,
  parameter int MEM_SLOTS = 15
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  cfg_we,
  input  wire logic  cfg_wdata,
  pcte_in_if.sink    in_ch,
  pcte_out_if.source out_ch
);

  localparam int REG_CNT_W = $clog2(REG_SLOTS + 1);
  localparam int MEM_CNT_W = $clog2(MEM_SLOTS + 1);

  state_t                state_r, state_nxt;
  logic [SLOT_IDX_W-1:0] idx_r, idx_nxt;
  logic [KEY_W-1:0]      key_r, key_nxt;
  logic [VAL_W-1:0]      val_r, val_nxt;
  logic                  sel_mem_r, sel_mem_nxt;
  logic [REG_CNT_W-1:0]  reg_cnt_r, reg_cnt_nxt;
  logic [MEM_CNT_W-1:0]  mem_cnt_r, mem_cnt_nxt;
  logic                  psw_r, psw_nxt;
  logic [7:0]            flags_r, flags_nxt;
  logic [7:0]            status_r, status_nxt;
  logic                  en_r;

  logic                  ov_r, ov_nxt;
  logic [1:0]            okind_r;
  logic [KEY_W-1:0]      okey_r;
  logic [VAL_W-1:0]      oval_r;
  logic                  olast_r;

  logic                  out_load;
  kind_t                 rec_kind;
  logic [KEY_W-1:0]      rec_key;
  logic [VAL_W-1:0]      rec_val;
  logic                  rec_last;
  logic                  out_free;

  kv_req_t               rg_req, mm_req;
  kv_entry_t             rg_rd, mm_rd;

  logic [SLOT_IDX_W-1:0] idx_inc;
  logic [SLOT_IDX_W-1:0] reg_cnt_x, mem_cnt_x;
  logic [SLOT_IDX_W-1:0] scan_cnt, scan_slots;
  logic [KEY_W-1:0]      scan_key;
  logic                  in_xfer;

  pcte_kv_ram #(.DEPTH(REG_SLOTS)) u_reg_ram (
    .clk     (clk),
    .req     (rg_req),
    .rd_data (rg_rd)
  );

  pcte_kv_ram #(.DEPTH(MEM_SLOTS)) u_mem_ram (
    .clk     (clk),
    .req     (mm_req),
    .rd_data (mm_rd)
  );

  assign idx_inc    = idx_r + 1'b1;
  assign reg_cnt_x  = SLOT_IDX_W'(reg_cnt_r);
  assign mem_cnt_x  = SLOT_IDX_W'(mem_cnt_r);
  assign scan_cnt   = sel_mem_r ? mem_cnt_x : reg_cnt_x;
  assign scan_slots = sel_mem_r ? SLOT_IDX_W'(MEM_SLOTS) : SLOT_IDX_W'(REG_SLOTS);
  assign scan_key   = sel_mem_r ? mm_rd.key : rg_rd.key;
  assign out_free   = !ov_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer    = in_ch.valid && in_ch.ready;

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    key_nxt     = key_r;
    val_nxt     = val_r;
    sel_mem_nxt = sel_mem_r;
    reg_cnt_nxt = reg_cnt_r;
    mem_cnt_nxt = mem_cnt_r;
    psw_nxt     = psw_r;
    flags_nxt   = flags_r;
    status_nxt  = status_r;
    rg_req      = '0;
    mm_req      = '0;
    out_load    = 1'b0;
    rec_kind    = KIND_HEADER;
    rec_key     = '0;
    rec_val     = '0;
    rec_last    = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_ch.mode)
            MODE_RESTART: begin
              psw_nxt     = 1'b0;
              reg_cnt_nxt = '0;
              mem_cnt_nxt = '0;
              flags_nxt   = in_ch.flags_in;
              status_nxt  = in_ch.status_in;
            end
            MODE_FLAGS: begin
              flags_nxt = in_ch.flags_in;
              psw_nxt   = 1'b1;
            end
            MODE_STATUS: begin
              status_nxt = in_ch.status_in;
              psw_nxt    = 1'b1;
            end
            MODE_REG_WR: begin
              key_nxt     = KEY_W'(in_ch.reg_index);
              val_nxt     = in_ch.reg_value;
              sel_mem_nxt = 1'b0;
              idx_nxt     = '0;
              if (reg_cnt_r == '0) begin
                rg_req.we    = 1'b1;
                rg_req.wkey  = KEY_W'(in_ch.reg_index);
                rg_req.wval  = in_ch.reg_value;
                reg_cnt_nxt  = REG_CNT_W'(1);
              end else begin
                rg_req.re = 1'b1;
                state_nxt = ST_SCAN;
              end
            end
            MODE_MEM_WR: begin
              key_nxt     = in_ch.mem_address;
              val_nxt     = VAL_W'(in_ch.mem_value);
              sel_mem_nxt = 1'b1;
              idx_nxt     = '0;
              if (mem_cnt_r == '0) begin
                mm_req.we    = 1'b1;
                mm_req.wkey  = in_ch.mem_address;
                mm_req.wval  = VAL_W'(in_ch.mem_value);
                mem_cnt_nxt  = MEM_CNT_W'(1);
              end else begin
                mm_req.re = 1'b1;
                state_nxt = ST_SCAN;
              end
            end
            MODE_END: begin
              if (en_r) begin
                state_nxt = ST_HEAD;
              end else begin
                psw_nxt     = 1'b0;
                reg_cnt_nxt = '0;
                mem_cnt_nxt = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (scan_key == key_r) begin
          rg_req.we    = !sel_mem_r;
          mm_req.we    = sel_mem_r;
          rg_req.waddr = idx_r;
          mm_req.waddr = idx_r;
          state_nxt    = ST_IDLE;
        end else if (idx_inc == scan_cnt) begin
          if (scan_cnt < scan_slots) begin
            rg_req.we    = !sel_mem_r;
            mm_req.we    = sel_mem_r;
            rg_req.waddr = scan_cnt;
            mm_req.waddr = scan_cnt;
            if (sel_mem_r) begin
              mem_cnt_nxt = mem_cnt_r + 1'b1;
            end else begin
              reg_cnt_nxt = reg_cnt_r + 1'b1;
            end
          end
          state_nxt = ST_IDLE;
        end else begin
          rg_req.re    = !sel_mem_r;
          mm_req.re    = sel_mem_r;
          rg_req.raddr = idx_inc;
          mm_req.raddr = idx_inc;
          idx_nxt      = idx_inc;
        end
        rg_req.wkey = key_r;
        rg_req.wval = val_r;
        mm_req.wkey = key_r;
        mm_req.wval = val_r;
      end

      ST_HEAD, ST_PSW: begin
        if (out_free) begin
          out_load = 1'b1;
          if (state_r == ST_HEAD) begin
            rec_kind = KIND_HEADER;
            rec_val  = VAL_W'((psw_r ? HDR_PSW_FLAG : 8'h00)
                              | {1'b0, HDR_REG_W'(reg_cnt_r), HDR_MEM_W'(mem_cnt_r)});
            rec_last = !psw_r && (reg_cnt_r == '0) && (mem_cnt_r == '0);
          end else begin
            rec_kind = KIND_PSW;
            rec_key  = KEY_W'(status_r);
            rec_val  = VAL_W'(flags_r);
            rec_last = (reg_cnt_r == '0) && (mem_cnt_r == '0);
          end
          idx_nxt = '0;
          if (state_r == ST_HEAD && psw_r) begin
            state_nxt = ST_PSW;
          end else if (reg_cnt_r != '0) begin
            rg_req.re = 1'b1;
            state_nxt = ST_REG;
          end else if (mem_cnt_r != '0) begin
            mm_req.re = 1'b1;
            state_nxt = ST_MEM;
          end else begin
            psw_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_REG: begin
        if (out_free) begin
          out_load = 1'b1;
          rec_kind = KIND_REG;
          rec_key  = rg_rd.key;
          rec_val  = rg_rd.val;
          rec_last = (idx_inc == reg_cnt_x) && (mem_cnt_r == '0);
          if (idx_inc != reg_cnt_x) begin
            rg_req.re    = 1'b1;
            rg_req.raddr = idx_inc;
            idx_nxt      = idx_inc;
          end else if (mem_cnt_r != '0) begin
            mm_req.re = 1'b1;
            idx_nxt   = '0;
            state_nxt = ST_MEM;
          end else begin
            psw_nxt     = 1'b0;
            reg_cnt_nxt = '0;
            state_nxt   = ST_IDLE;
          end
        end
      end

      ST_MEM: begin
        if (out_free) begin
          out_load = 1'b1;
          rec_kind = KIND_MEM;
          rec_key  = mm_rd.key;
          rec_val  = mm_rd.val;
          rec_last = (idx_inc == mem_cnt_x);
          if (idx_inc != mem_cnt_x) begin
            mm_req.re    = 1'b1;
            mm_req.raddr = idx_inc;
            idx_nxt      = idx_inc;
          end else begin
            psw_nxt     = 1'b0;
            reg_cnt_nxt = '0;
            mem_cnt_nxt = '0;
            state_nxt   = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign ov_nxt = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : ov_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      reg_cnt_r <= '0;
      mem_cnt_r <= '0;
      psw_r     <= 1'b0;
      flags_r   <= '0;
      status_r  <= '0;
      en_r      <= 1'b1;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      reg_cnt_r <= reg_cnt_nxt;
      mem_cnt_r <= mem_cnt_nxt;
      psw_r     <= psw_nxt;
      flags_r   <= flags_nxt;
      status_r  <= status_nxt;
      ov_r      <= ov_nxt;
      if (cfg_we) begin
        en_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    key_r     <= key_nxt;
    val_r     <= val_nxt;
    sel_mem_r <= sel_mem_nxt;
    if (out_load) begin
      okind_r <= rec_kind;
      okey_r  <= rec_key;
      oval_r  <= rec_val;
      olast_r <= rec_last;
    end
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.record_kind  = okind_r;
  assign out_ch.record_key   = okey_r;
  assign out_ch.record_value = oval_r;
  assign out_ch.last         = olast_r;

  `PCTE_ASSERT_RST(a_reg_cnt_bound, clk, rst_n, reg_cnt_r <= REG_CNT_W'(REG_SLOTS), "register entry count above its slot limit")
  `PCTE_ASSERT_RST(a_mem_cnt_bound, clk, rst_n, mem_cnt_r <= MEM_CNT_W'(MEM_SLOTS), "memory entry count above its slot limit")
  `PCTE_ASSERT_RST(a_scan_idx, clk, rst_n, (state_r == ST_SCAN) |-> (idx_r < scan_cnt), "scan index beyond the filled entries")
  `PCTE_ASSERT_RST(a_reg_emit_idx, clk, rst_n, (state_r == ST_REG) |-> (idx_r < reg_cnt_x), "register record index beyond the filled entries")

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the per-cycle change trace encoder.
// Drives trace events, predicts every change record and checks each one.
// Depends on pcte_pkg, the pcte_in_if/pcte_out_if interfaces and the top level.
`default_nettype none

module tb_top;
  import pcte_pkg::*;

  localparam int REG_LIMIT   = 7;
  localparam int MEM_LIMIT   = 15;
  localparam int WAIT_MAX    = 12;
  localparam int SETTLE      = 40;
  localparam int CYCLE_LIMIT = 300000;

  localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [7:0]        flags;
    logic [7:0]        status;
    logic [3:0]        reg_idx;
    logic [15:0]       reg_val;
    logic [15:0]       addr;
    logic [7:0]        byte_val;
  } trace_event_t;

  typedef struct {
    kind_t       kind;
    logic [15:0] key;
    logic [15:0] value;
    logic        last;
  } change_record_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  pcte_in_if  in_bus ();
  pcte_out_if out_bus ();

  per_cycle_change_trace_encoder u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_bus),
    .out_ch   (out_bus)
  );

  always #10 clk = ~clk;

  trace_event_t   event_backlog[$];
  change_record_t pending_records[$];

  // Copy of the encoder state, kept in step with accepted transfers.
  logic        trace_on;
  logic        psw_seen;
  logic [7:0]  flags_now;
  logic [7:0]  status_now;
  int          reg_cnt;
  logic [3:0]  reg_key[REG_LIMIT];
  logic [15:0] reg_data[REG_LIMIT];
  int          mem_cnt;
  logic [15:0] mem_key[MEM_LIMIT];
  logic [7:0]  mem_data[MEM_LIMIT];

  int  fail_count = 0;
  int  events_taken = 0;
  int  records_checked = 0;
  int  cycles_traced = 0;
  int  cycles_silent = 0;
  int  writes_dropped = 0;
  int  cycle_count = 0;
  int  in_wait_max = WAIT_MAX;
  int  out_wait_max = WAIT_MAX;
  int  in_idle = 0;
  int  out_hold = 0;
  logic in_fire = 1'b0;
  logic out_fire = 1'b0;

  function automatic int draw_wait(int max_wait);
    if (max_wait == 0 || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, max_wait);
  endfunction

  function automatic void clear_tracking();
    psw_seen = 1'b0;
    reg_cnt  = 0;
    mem_cnt  = 0;
  endfunction

  function automatic change_record_t make_record(kind_t kind, logic [15:0] key,
                                                 logic [15:0] value);
    change_record_t rec;
    rec.kind  = kind;
    rec.key   = key;
    rec.value = value;
    rec.last  = 1'b0;
    return rec;
  endfunction

  function automatic void close_cycle();
    change_record_t batch[$];
    logic [7:0]     head;
    if (!trace_on) begin
      cycles_silent++;
      clear_tracking();
      return;
    end
    head = (psw_seen ? HDR_PSW_FLAG : 8'h00) | 8'(reg_cnt << 4) | 8'(mem_cnt);
    batch.push_back(make_record(KIND_HEADER, 16'h0000, {8'h00, head}));
    if (psw_seen) batch.push_back(make_record(KIND_PSW, {8'h00, status_now}, {8'h00, flags_now}));
    for (int i = 0; i < reg_cnt; i++)
      batch.push_back(make_record(KIND_REG, {12'h000, reg_key[i]}, reg_data[i]));
    for (int i = 0; i < mem_cnt; i++)
      batch.push_back(make_record(KIND_MEM, mem_key[i], {8'h00, mem_data[i]}));
    batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) pending_records.push_back(batch[i]);
    cycles_traced++;
    clear_tracking();
  endfunction

  function automatic void track_event(trace_event_t ev);
    bit hit;
    hit = 1'b0;
    case (ev.mode)
      MODE_RESTART: begin
        clear_tracking();
        flags_now  = ev.flags;
        status_now = ev.status;
      end
      MODE_FLAGS: begin
        flags_now = ev.flags;
        psw_seen  = 1'b1;
      end
      MODE_STATUS: begin
        status_now = ev.status;
        psw_seen   = 1'b1;
      end
      MODE_REG_WR: begin
        for (int i = 0; i < reg_cnt; i++) begin
          if (reg_key[i] == ev.reg_idx) begin
            reg_data[i] = ev.reg_val;
            hit = 1'b1;
          end
        end
        if (!hit && reg_cnt < REG_LIMIT) begin
          reg_key[reg_cnt]  = ev.reg_idx;
          reg_data[reg_cnt] = ev.reg_val;
          reg_cnt++;
        end else if (!hit) begin
          writes_dropped++;
        end
      end
      MODE_MEM_WR: begin
        for (int i = 0; i < mem_cnt; i++) begin
          if (mem_key[i] == ev.addr) begin
            mem_data[i] = ev.byte_val;
            hit = 1'b1;
          end
        end
        if (!hit && mem_cnt < MEM_LIMIT) begin
          mem_key[mem_cnt]  = ev.addr;
          mem_data[mem_cnt] = ev.byte_val;
          mem_cnt++;
        end else if (!hit) begin
          writes_dropped++;
        end
      end
      MODE_END: close_cycle();
      default: ;
    endcase
  endfunction

  // Input side: prediction on every accepted transfer, plus the register write.
  always @(posedge clk) begin
    trace_event_t ev;
    in_fire <= rst_n && in_bus.valid && in_bus.ready;
    if (!rst_n) begin
      trace_on   = 1'b1;
      flags_now  = 8'h00;
      status_now = 8'h00;
      clear_tracking();
    end else begin
      if (cfg_we) trace_on = cfg_wdata;
      if (in_bus.valid && in_bus.ready) begin
        ev.mode     = in_bus.mode;
        ev.flags    = in_bus.flags_in;
        ev.status   = in_bus.status_in;
        ev.reg_idx  = in_bus.reg_index;
        ev.reg_val  = in_bus.reg_value;
        ev.addr     = in_bus.mem_address;
        ev.byte_val = in_bus.mem_value;
        events_taken++;
        track_event(ev);
      end
    end
  end

  // Output side: every record transfer is checked against the oldest expectation.
  always @(posedge clk) begin
    change_record_t want;
    out_fire <= rst_n && out_bus.valid && out_bus.ready;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_records.size() == 0) begin
        $error("unexpected record: kind %0d key %0h value %0h last %0b",
               out_bus.record_kind, out_bus.record_key, out_bus.record_value, out_bus.last);
        fail_count++;
      end else begin
        want = pending_records.pop_front();
        records_checked++;
        if (out_bus.record_kind !== want.kind) begin
          $error("record_kind mismatch: expected %0d, actual %0d", want.kind,
                 out_bus.record_kind);
          fail_count++;
        end
        if (out_bus.record_key !== want.key) begin
          $error("record_key mismatch: expected %0h, actual %0h", want.key, out_bus.record_key);
          fail_count++;
        end
        if (out_bus.record_value !== want.value) begin
          $error("record_value mismatch: expected %0h, actual %0h", want.value,
                 out_bus.record_value);
          fail_count++;
        end
        if (out_bus.last !== want.last) begin
          $error("last mismatch: expected %0b, actual %0b", want.last, out_bus.last);
          fail_count++;
        end
      end
    end
  end

  always @(negedge clk) begin
    trace_event_t ev;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      in_idle = 0;
    end else if (!in_bus.valid || in_fire) begin
      if (in_idle > 0 || event_backlog.size() == 0) begin
        if (in_idle > 0) in_idle--;
        in_bus.valid <= 1'b0;
      end else begin
        ev = event_backlog.pop_front();
        in_bus.valid       <= 1'b1;
        in_bus.mode        <= ev.mode;
        in_bus.flags_in    <= ev.flags;
        in_bus.status_in   <= ev.status;
        in_bus.reg_index   <= ev.reg_idx;
        in_bus.reg_value   <= ev.reg_val;
        in_bus.mem_address <= ev.addr;
        in_bus.mem_value   <= ev.byte_val;
        in_idle = draw_wait(in_wait_max);
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_fire) out_hold = draw_wait(out_wait_max);
      if (out_hold > 0) begin
        out_hold--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic add_event(logic [MODE_W-1:0] mode, logic [7:0] flags, logic [7:0] status,
                           logic [3:0] reg_idx, logic [15:0] reg_val, logic [15:0] addr,
                           logic [7:0] byte_val);
    trace_event_t ev;
    ev.mode     = mode;
    ev.flags    = flags;
    ev.status   = status;
    ev.reg_idx  = reg_idx;
    ev.reg_val  = reg_val;
    ev.addr     = addr;
    ev.byte_val = byte_val;
    event_backlog.push_back(ev);
  endtask

  task automatic add_random(logic [MODE_W-1:0] mode);
    add_event(mode, 8'($urandom), 8'($urandom), 4'($urandom), 16'($urandom), 16'($urandom),
              8'($urandom));
  endtask

  task automatic add_reg(logic [3:0] reg_idx, logic [15:0] reg_val);
    add_event(MODE_REG_WR, 8'($urandom), 8'($urandom), reg_idx, reg_val, 16'($urandom),
              8'($urandom));
  endtask

  task automatic add_mem(logic [15:0] addr, logic [7:0] byte_val);
    add_event(MODE_MEM_WR, 8'($urandom), 8'($urandom), 4'($urandom), 16'($urandom), addr,
              byte_val);
  endtask

  // One emulated cycle: random updates and writes closed by an end of cycle.
  // Heavy cycles mostly use fresh keys so that both tables overflow.
  task automatic add_machine_cycle(ref int counted);
    bit          heavy;
    int          n_ev;
    int          pick;
    int          reg_seq;
    int          mem_seq;
    logic [15:0] base;
    heavy   = ($urandom_range(0, 5) == 0);
    n_ev    = heavy ? $urandom_range(26, 36) : $urandom_range(0, 10);
    base    = 16'($urandom);
    reg_seq = $urandom_range(0, 15);
    mem_seq = 0;
    if ($urandom_range(0, 7) == 0) begin
      add_random(MODE_RESTART);
      counted++;
    end
    for (int i = 0; i < n_ev; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        add_random(MODE_FLAGS);
      end else if (pick < 12) begin
        add_random(MODE_STATUS);
      end else if (pick < 45) begin
        if (heavy && $urandom_range(0, 4) != 0) begin
          add_reg(4'(reg_seq), 16'($urandom));
          reg_seq++;
        end else begin
          add_reg(4'($urandom), 16'($urandom));
        end
      end else if (pick < 96) begin
        if (heavy && $urandom_range(0, 4) != 0) begin
          add_mem(base + 16'(mem_seq), 8'($urandom));
          mem_seq++;
        end else if ($urandom_range(0, 3) == 0) begin
          add_mem(16'($urandom), 8'($urandom));
        end else begin
          add_mem(base + 16'($urandom_range(0, 19)), 8'($urandom));
        end
      end else begin
        add_random($urandom_range(0, 1) ? MODE_SPARE6 : MODE_SPARE7);
        counted--;
      end
      counted++;
    end
    add_random(MODE_END);
    counted++;
  endtask

  task automatic run_cycles(int target);
    int counted;
    counted = 0;
    while (counted < target) add_machine_cycle(counted);
  endtask

  task automatic drain();
    while (event_backlog.size() != 0 || in_bus.valid) @(posedge clk);
    while (pending_records.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_trace(logic on);
    @(negedge clk);
    cfg_wdata <= on;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.mode        = MODE_RESTART;
    in_bus.flags_in    = 8'h00;
    in_bus.status_in   = 8'h00;
    in_bus.reg_index   = 4'h0;
    in_bus.reg_value   = 16'h0000;
    in_bus.mem_address = 16'h0000;
    in_bus.mem_value   = 8'h00;
    out_bus.ready      = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    set_trace(1'b1);
    add_random(MODE_END);
    add_event(MODE_RESTART, 8'hFF, 8'hFF, 4'h0, 16'h0000, 16'h0000, 8'h00);
    add_random(MODE_END);
    add_event(MODE_FLAGS, 8'hA5, 8'h00, 4'h0, 16'h0000, 16'h0000, 8'h00);
    add_event(MODE_STATUS, 8'h00, 8'h5A, 4'h0, 16'h0000, 16'h0000, 8'h00);
    add_reg(4'h0, 16'hFFFF);
    add_reg(4'hF, 16'h0000);
    add_reg(4'h0, 16'h1234);
    add_mem(16'hFFFF, 8'hFF);
    add_mem(16'h0000, 8'h00);
    add_mem(16'hFFFF, 8'h11);
    add_random(MODE_SPARE6);
    add_random(MODE_SPARE7);
    add_random(MODE_END);
    add_event(MODE_FLAGS, 8'h00, 8'h00, 4'h0, 16'h0000, 16'h0000, 8'h00);
    add_event(MODE_RESTART, 8'h3C, 8'hC3, 4'h0, 16'h0000, 16'h0000, 8'h00);
    add_reg(4'h8, 16'h8000);
    add_random(MODE_END);
    add_event(MODE_STATUS, 8'h00, 8'hFF, 4'h0, 16'h0000, 16'h0000, 8'h00);
    add_random(MODE_END);
    add_mem(16'h8000, 8'h80);
    add_random(MODE_END);
    drain();

    set_trace(1'b0);
    run_cycles(15);
    drain();

    set_trace(1'b1);
    run_cycles(55);
    drain();

    in_wait_max  = 0;
    out_wait_max = 0;
    run_cycles(30);
    drain();
    in_wait_max  = WAIT_MAX;
    out_wait_max = WAIT_MAX;

    set_trace(1'b0);
    run_cycles(8);
    drain();

    set_trace(1'b1);
    run_cycles(15);
    drain();

    $display("Covered %0d event transfers, %0d records checked, %0d traced cycles,",
             events_taken, records_checked, cycles_traced);
    $display("%0d cycles with tracing off and %0d writes dropped on full tables.",
             cycles_silent, writes_dropped);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
